// ===== hdl/gcd_pkg.sv =====
// Shared types, widths and constant tables for the great-circle distance core.
package gcd_pkg;

    localparam int CORDIC_STEPS_DEF = 24;

    // datapath widths
    localparam int H_W        = 30;   // angle in half-microdegrees
    localparam int MAG_W      = 28;   // folded angle magnitude
    localparam int RM_W       = 18;   // half of the radian multiplier
    localparam int RAD_W      = 50;   // radians in Q48, magnitude
    localparam int XY_W       = 43;   // CORDIC x/y, Q40
    localparam int Z_W        = 51;   // CORDIC angle, Q48
    localparam int ZR_W       = 18;   // residual angle, Q30
    localparam int YR_W       = 30;   // residual y after vectoring
    localparam int Q31_W      = 33;   // sines and cosines, Q31
    localparam int A_W        = 61;   // haversine term a, Q60, clamped
    localparam int SQ_W       = 64;   // square root recurrence
    localparam int SQRT_STEPS = 32;
    localparam int ROOT_W     = 32;
    localparam int ZU_W       = Z_W - 1;
    localparam int R2_W       = 24;
    localparam int DIST_W     = 25;

    typedef logic signed [XY_W-1:0]  xy_t;
    typedef logic signed [Z_W-1:0]   ang_t;
    typedef logic signed [Q31_W-1:0] q31_t;
    typedef logic [SQ_W-1:0]         sq_t;

    localparam logic [31:0]         KINV_Q32 = 32'h9B74EDA8;
    localparam logic signed [H_W:0] TURN_H   = 31'sd720000000;
    localparam logic signed [H_W:0] HALF_H   = 31'sd360000000;
    localparam logic signed [H_W:0] QUART_H  = 31'sd180000000;
    localparam logic [A_W-1:0]      ONE_Q60  = 61'd1 << 60;
    localparam logic [R2_W-1:0]     TWO_R    = 24'd12742000;
    localparam logic [DIST_W-1:0]   DIST_MAX = 25'd20015087;

    // unsigned quotient by shift and subtract, used only for the constant tables
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] rem;
        q   = 64'd0;
        rem = 65'd0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d})
            begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in Q60 by its power series, i >= 1
    function automatic logic [63:0] atan_pow2_q60(input int i);
        logic [63:0] term;
        logic [63:0] k;
        logic [63:0] v;
        logic [63:0] sum;
        logic        neg;
        term = 64'd1 << (60 - i);
        k    = 64'd1;
        sum  = 64'd0;
        neg  = 1'b0;
        for (int j = 0; j < 64; j++)
        begin
            if (term != 64'd0)
            begin
                v    = udiv64(term, k);
                sum  = neg ? sum - v : sum + v;
                term = term >> (2 * i);
                k    = k + 64'd2;
                neg  = ~neg;
            end
        end
        return sum;
    endfunction

    // atan(1/3) in Q60
    function automatic logic [63:0] atan_inv3_q60();
        logic [63:0] term;
        logic [63:0] k;
        logic [63:0] v;
        logic [63:0] sum;
        logic        neg;
        term = udiv64(64'd1 << 60, 64'd3);
        k    = 64'd1;
        sum  = 64'd0;
        neg  = 1'b0;
        for (int j = 0; j < 64; j++)
        begin
            if (term != 64'd0)
            begin
                v    = udiv64(term, k);
                sum  = neg ? sum - v : sum + v;
                term = udiv64(term, 64'd9);
                k    = k + 64'd2;
                neg  = ~neg;
            end
        end
        return sum;
    endfunction

    function automatic logic [63:0] quarter_pi_q60();
        return atan_pow2_q60(1) + atan_inv3_q60();
    endfunction

    // arctangent table entry, Q48 rounded
    function automatic logic [63:0] atan_q48(input int i);
        logic [63:0] q;
        q = (i == 0) ? quarter_pi_q60() : atan_pow2_q60(i);
        return (q + 64'd2048) >> 12;
    endfunction

    localparam logic [63:0] RAD_MUL =
        (quarter_pi_q60() * 64'd16 + 64'd180000000) / 64'd360000000;
    localparam logic [RM_W-1:0] RAD_MUL_HI = RAD_MUL[2*RM_W-1:RM_W];
    localparam logic [RM_W-1:0] RAD_MUL_LO = RAD_MUL[RM_W-1:0];

endpackage

// ===== hdl/great_circle_distance_core.sv =====
// Great-circle (haversine) distance core: top level of the cell pipeline.
// Throughput: one transfer per cycle; every stage is a register, busy stays low.
// Depth is set by the two CORDIC cell rows and the 32-cell square root rows.
// Reset (rst_n, asynchronous, active low) clears all valid flags; no result follows.
module great_circle_distance_core
    import gcd_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [27:0]       lat_a,
    input  logic signed [28:0]       lon_a,
    input  logic signed [27:0]       lat_b,
    input  logic signed [28:0]       lon_b,
    output logic                     done,
    output logic [DIST_W-1:0]        distance_m
);

    localparam int LATENCY = 2 * CORDIC_STEPS + 49;
    localparam int P_W     = 2 * Q31_W;

    localparam logic signed [P_W-1:0] RND31 = 66'sh40000000;
    localparam logic signed [P_W-1:0] RND2  = 66'sd2;

    // Every stage is fed in every cycle, so the core never holds off a start.
    assign busy = 1'b0;

    // ---------------------------------------------------------------------------------------
    // Input stage: the four angles fed to the sine/cosine units, in half-microdegrees.
    // Differences of microdegrees are half-angle arguments; doubled latitudes are full ones.
    // ---------------------------------------------------------------------------------------
    logic signed [H_W-1:0] hlat_reg;
    logic signed [H_W-1:0] hlon_reg;
    logic signed [H_W-1:0] hla_reg;
    logic signed [H_W-1:0] hlb_reg;
    logic                  v0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        hlat_reg <= H_W'(lat_b) - H_W'(lat_a);
        hlon_reg <= H_W'(lon_b) - H_W'(lon_a);
        hla_reg  <= H_W'(lat_a) <<< 1;
        hlb_reg  <= H_W'(lat_b) <<< 1;
    end

    // ---------------------------------------------------------------------------------------
    // Four sine/cosine units in lock step; only the first one's valid flag is tracked.
    // ---------------------------------------------------------------------------------------
    q31_t sd;
    q31_t so;
    q31_t ca;
    q31_t cb;
    logic sc_valid;

    gcd_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_dlat (
        .clk(clk), .rst_n(rst_n), .in_valid(v0_reg), .h(hlat_reg),
        .out_valid(sc_valid), .sin_q31(sd), .cos_q31()
    );

    gcd_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_dlon (
        .clk(clk), .rst_n(rst_n), .in_valid(v0_reg), .h(hlon_reg),
        .out_valid(), .sin_q31(so), .cos_q31()
    );

    gcd_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_lat_a (
        .clk(clk), .rst_n(rst_n), .in_valid(v0_reg), .h(hla_reg),
        .out_valid(), .sin_q31(), .cos_q31(ca)
    );

    gcd_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_lat_b (
        .clk(clk), .rst_n(rst_n), .in_valid(v0_reg), .h(hlb_reg),
        .out_valid(), .sin_q31(), .cos_q31(cb)
    );

    // ---------------------------------------------------------------------------------------
    // Haversine term a in Q60: one multiply per stage, rounding in the stage after.
    // ---------------------------------------------------------------------------------------
    logic signed [P_W-1:0] ccf_reg;
    logic signed [P_W-1:0] s1sq_p1_reg;
    logic signed [P_W-1:0] s1sq_p2_reg;
    logic signed [P_W-1:0] s1sq_p3_reg;
    logic signed [P_W-1:0] s1sq_p4_reg;
    logic signed [P_W-1:0] s1sq_p5_reg;
    q31_t                  so_p1_reg;
    q31_t                  so_p2_reg;
    q31_t                  so_p3_reg;
    q31_t                  so_p4_reg;
    q31_t                  cc_reg;
    logic signed [P_W-1:0] tf_reg;
    q31_t                  t_reg;
    logic signed [P_W-1:0] ts_reg;
    logic [A_W-1:0]        a_reg;
    logic [5:0]            vp_reg;

    logic signed [P_W-1:0] cc_rnd;
    logic signed [P_W-1:0] t_rnd;
    logic signed [P_W-1:0] a_sum;
    logic [A_W-1:0]        a_next;

    always_comb
    begin
        cc_rnd = (ccf_reg + RND31) >>> 31;
        t_rnd  = (tf_reg + RND31) >>> 31;
        a_sum  = ((s1sq_p5_reg + RND2) >>> 2) + ((ts_reg + RND2) >>> 2);
        if (a_sum[P_W-1])
        begin
            a_next = '0;
        end
        else if (a_sum > P_W'(ONE_Q60))
        begin
            a_next = ONE_Q60;
        end
        else
        begin
            a_next = a_sum[A_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg <= '0;
        end
        else
        begin
            vp_reg <= {vp_reg[4:0], sc_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        ccf_reg     <= ca * cb;
        s1sq_p1_reg <= sd * sd;
        so_p1_reg   <= so;
        cc_reg      <= q31_t'(cc_rnd);
        s1sq_p2_reg <= s1sq_p1_reg;
        so_p2_reg   <= so_p1_reg;
        tf_reg      <= cc_reg * so_p2_reg;
        s1sq_p3_reg <= s1sq_p2_reg;
        so_p3_reg   <= so_p2_reg;
        t_reg       <= q31_t'(t_rnd);
        s1sq_p4_reg <= s1sq_p3_reg;
        so_p4_reg   <= so_p3_reg;
        ts_reg      <= t_reg * so_p4_reg;
        s1sq_p5_reg <= s1sq_p4_reg;
        a_reg       <= a_next;
    end

    // ---------------------------------------------------------------------------------------
    // sqrt(a) and sqrt(1 - a): two rows of digit cells, Q62 in, Q31 out.
    // ---------------------------------------------------------------------------------------
    sq_t  va_c   [SQRT_STEPS+1];
    sq_t  ra_c   [SQRT_STEPS+1];
    sq_t  vb_c   [SQRT_STEPS+1];
    sq_t  rb_c   [SQRT_STEPS+1];
    logic sv_c   [SQRT_STEPS+1];

    assign va_c[0] = {1'b0, a_reg, 2'b00};
    assign vb_c[0] = {1'b0, ONE_Q60 - a_reg, 2'b00};
    assign ra_c[0] = '0;
    assign rb_c[0] = '0;
    assign sv_c[0] = vp_reg[5];

    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_sqrt
        gcd_sqrt_cell #(.STEP(i)) u_sqrt_a (
            .clk(clk), .rst_n(rst_n), .in_valid(sv_c[i]),
            .in_v(va_c[i]), .in_res(ra_c[i]),
            .out_valid(sv_c[i+1]), .out_v(va_c[i+1]), .out_res(ra_c[i+1])
        );
        gcd_sqrt_cell #(.STEP(i)) u_sqrt_b (
            .clk(clk), .rst_n(rst_n), .in_valid(sv_c[i]),
            .in_v(vb_c[i]), .in_res(rb_c[i]),
            .out_valid(), .out_v(vb_c[i+1]), .out_res(rb_c[i+1])
        );
    end

    // ---------------------------------------------------------------------------------------
    // atan2(sqrt(a), sqrt(1 - a)) by a vectoring cell row, both roots scaled to Q40.
    // ---------------------------------------------------------------------------------------
    xy_t  vx_c [CORDIC_STEPS+1];
    xy_t  vy_c [CORDIC_STEPS+1];
    ang_t vz_c [CORDIC_STEPS+1];
    logic vv_c [CORDIC_STEPS+1];

    assign vx_c[0] = xy_t'({rb_c[SQRT_STEPS][ROOT_W-1:0], 9'd0});
    assign vy_c[0] = xy_t'({ra_c[SQRT_STEPS][ROOT_W-1:0], 9'd0});
    assign vz_c[0] = '0;
    assign vv_c[0] = sv_c[SQRT_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_vec
        gcd_vec_cell #(.STEP(i)) u_cell (
            .clk(clk), .rst_n(rst_n), .in_valid(vv_c[i]),
            .in_x(vx_c[i]), .in_y(vy_c[i]), .in_z(vz_c[i]),
            .out_valid(vv_c[i+1]), .out_x(vx_c[i+1]), .out_y(vy_c[i+1]), .out_z(vz_c[i+1])
        );
    end

    // ---------------------------------------------------------------------------------------
    // Residual correction, clamp at zero, scale by 2R, round to the nearest metre and cap at DIST_MAX.
    // ---------------------------------------------------------------------------------------
    logic signed [YR_W-1:0]    y_res;
    logic signed [YR_W+32:0]   corr_reg;
    ang_t                      zc_reg;
    ang_t                      z_tot;
    logic [ZU_W-1:0]           zu_next;
    logic [ZU_W-1:0]           zu_reg;
    logic [ZU_W:0]             hi_reg;
    logic [R2_W+24-1:0]        lo_reg;
    logic [ZU_W:0]             d_sum;
    logic [ZU_W-24:0]          d_full;
    logic [DIST_W-1:0]         dist_next;
    logic [DIST_W-1:0]         dist_reg;
    logic                      done_reg;
    logic [2:0]                vv_reg;

    assign y_res = YR_W'(vy_c[CORDIC_STEPS]);

    always_comb
    begin
        z_tot     = zc_reg + ang_t'(corr_reg >>> 24);
        zu_next   = z_tot[Z_W-1] ? '0 : z_tot[ZU_W-1:0];
        d_sum     = hi_reg + (ZU_W+1)'(lo_reg >> 24) + (ZU_W+1)'(24'h800000);
        d_full    = d_sum[ZU_W:24];
        dist_next = (d_full > (ZU_W-23)'(DIST_MAX)) ? DIST_MAX : d_full[DIST_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vv_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vv_reg   <= {vv_reg[1:0], vv_c[CORDIC_STEPS]};
            done_reg <= vv_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        corr_reg <= y_res * $signed({1'b0, KINV_Q32});
        zc_reg   <= vz_c[CORDIC_STEPS];
        zu_reg   <= zu_next;
        hi_reg   <= zu_reg[ZU_W-1:24] * TWO_R;
        lo_reg   <= zu_reg[23:0] * TWO_R;
        dist_reg <= dist_next;
    end

    assign done       = done_reg;
    assign distance_m = dist_reg;

`ifndef ASSERT_OFF
    // every accepted transfer comes out as a result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("result missing after an accepted transfer");

    // no result without a matching accepted transfer
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without a matching transfer");

    // the haversine term leaves its stage clamped to [0, 1]
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        vp_reg[5] |-> a_reg <= ONE_Q60)
        else $error("haversine term out of range");
`endif

endmodule

// ===== hdl/gcd_rot_cell.sv =====
// One rotation-mode CORDIC iteration with its pipeline register.
module gcd_rot_cell
    import gcd_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_flip,
    input  xy_t  in_x,
    input  xy_t  in_y,
    input  ang_t in_z,
    output logic out_valid,
    output logic out_flip,
    output xy_t  out_x,
    output xy_t  out_y,
    output ang_t out_z
);

    localparam ang_t ANGLE = ang_t'(atan_q48(STEP));

    xy_t  dx;
    xy_t  dy;
    xy_t  x_next;
    xy_t  y_next;
    ang_t z_next;
    logic valid_reg;
    logic flip_reg;
    xy_t  x_reg;
    xy_t  y_reg;
    ang_t z_reg;

    always_comb
    begin
        dx = in_y >>> STEP;
        dy = in_x >>> STEP;
        if (!in_z[Z_W-1])
        begin
            x_next = in_x - dx;
            y_next = in_y + dy;
            z_next = in_z - ANGLE;
        end
        else
        begin
            x_next = in_x + dx;
            y_next = in_y - dy;
            z_next = in_z + ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        flip_reg <= in_flip;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    assign out_valid = valid_reg;
    assign out_flip  = flip_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;

endmodule

// ===== hdl/gcd_sincos.sv =====
// Sine and cosine of a half-microdegree angle: reduction, CORDIC cell row, residual fix.
module gcd_sincos
    import gcd_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic signed [H_W-1:0] h,
    output logic                  out_valid,
    output q31_t                  sin_q31,
    output q31_t                  cos_q31
);

    localparam xy_t X_INIT = xy_t'({KINV_Q32, 8'd0});
    localparam logic signed [XY_W:0] RND9 = 44'sd256;

    // wrap into [-180, 180) degrees
    logic signed [H_W:0] h_ext;
    logic signed [H_W:0] r_next;
    logic signed [H_W:0] r_reg;
    logic                v1_reg;

    always_comb
    begin
        h_ext = {h[H_W-1], h};
        if (h_ext[H_W])
        begin
            r_next = (h_ext >= -HALF_H) ? h_ext : h_ext + TURN_H;
        end
        else
        begin
            r_next = (h_ext >= HALF_H) ? h_ext - TURN_H : h_ext;
        end
    end

    // fold into [-90, 90] degrees
    logic signed [H_W:0] sum_h;
    logic [MAG_W-1:0]    mag_next;
    logic [MAG_W-1:0]    mag_reg;
    logic                neg_next;
    logic                neg_reg;
    logic                flip_next;
    logic                flip2_reg;
    logic                v2_reg;

    always_comb
    begin
        sum_h = r_reg + HALF_H;
        if (r_reg > QUART_H)
        begin
            mag_next  = MAG_W'(HALF_H - r_reg);
            neg_next  = 1'b0;
            flip_next = 1'b1;
        end
        else if (r_reg < -QUART_H)
        begin
            mag_next  = MAG_W'(sum_h);
            neg_next  = (sum_h != '0);
            flip_next = 1'b1;
        end
        else
        begin
            mag_next  = MAG_W'(r_reg[H_W] ? -r_reg : r_reg);
            neg_next  = r_reg[H_W];
            flip_next = 1'b0;
        end
    end

    // radian conversion, split multiplier
    logic [MAG_W+RM_W-1:0] phi_reg;
    logic [MAG_W+RM_W-1:0] plo_reg;
    logic                  neg3_reg;
    logic                  flip3_reg;
    logic                  v3_reg;

    logic [63:0]      rad_sum;
    logic [RAD_W-1:0] rad;
    ang_t             z0_next;
    ang_t             z0_reg;
    logic             flip4_reg;
    logic             v4_reg;

    always_comb
    begin
        rad_sum = ({{(64-MAG_W-RM_W){1'b0}}, phi_reg} << RM_W)
                + {{(64-MAG_W-RM_W){1'b0}}, plo_reg} + 64'd8192;
        rad     = rad_sum[14 +: RAD_W];
        z0_next = neg3_reg ? -ang_t'({1'b0, rad}) : ang_t'({1'b0, rad});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg     <= r_next;
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        flip2_reg <= flip_next;
        phi_reg   <= mag_reg * RAD_MUL_HI;
        plo_reg   <= mag_reg * RAD_MUL_LO;
        neg3_reg  <= neg_reg;
        flip3_reg <= flip2_reg;
        z0_reg    <= z0_next;
        flip4_reg <= flip3_reg;
    end

    // CORDIC cell row
    xy_t  x_c [CORDIC_STEPS+1];
    xy_t  y_c [CORDIC_STEPS+1];
    ang_t z_c [CORDIC_STEPS+1];
    logic v_c [CORDIC_STEPS+1];
    logic f_c [CORDIC_STEPS+1];

    assign x_c[0] = X_INIT;
    assign y_c[0] = '0;
    assign z_c[0] = z0_reg;
    assign v_c[0] = v4_reg;
    assign f_c[0] = flip4_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        gcd_rot_cell #(
            .STEP(i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v_c[i]),
            .in_flip   (f_c[i]),
            .in_x      (x_c[i]),
            .in_y      (y_c[i]),
            .in_z      (z_c[i]),
            .out_valid (v_c[i+1]),
            .out_flip  (f_c[i+1]),
            .out_x     (x_c[i+1]),
            .out_y     (y_c[i+1]),
            .out_z     (z_c[i+1])
        );
    end

    // first-order residual correction
    logic signed [ZR_W-1:0]      zr;
    logic signed [XY_W+ZR_W-1:0] pxz_reg;
    logic signed [XY_W+ZR_W-1:0] pyz_reg;
    xy_t                         x5_reg;
    xy_t                         y5_reg;
    logic                        flip5_reg;
    logic                        v5_reg;

    assign zr = ZR_W'(z_c[CORDIC_STEPS] >>> 18);

    logic signed [XY_W:0] s_full;
    logic signed [XY_W:0] c_full;
    logic signed [XY_W:0] c_sign;
    logic signed [XY_W:0] s_rnd;
    logic signed [XY_W:0] c_rnd;
    q31_t                 sin_reg;
    q31_t                 cos_reg;
    logic                 v6_reg;

    always_comb
    begin
        s_full = (XY_W+1)'(y5_reg) + (XY_W+1)'(pxz_reg >>> 30);
        c_full = (XY_W+1)'(x5_reg) - (XY_W+1)'(pyz_reg >>> 30);
        c_sign = flip5_reg ? -c_full : c_full;
        s_rnd  = (s_full + RND9) >>> 9;
        c_rnd  = (c_sign + RND9) >>> 9;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= v_c[CORDIC_STEPS];
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pxz_reg   <= x_c[CORDIC_STEPS] * zr;
        pyz_reg   <= y_c[CORDIC_STEPS] * zr;
        x5_reg    <= x_c[CORDIC_STEPS];
        y5_reg    <= y_c[CORDIC_STEPS];
        flip5_reg <= f_c[CORDIC_STEPS];
        sin_reg   <= q31_t'(s_rnd);
        cos_reg   <= q31_t'(c_rnd);
    end

    assign out_valid = v6_reg;
    assign sin_q31   = sin_reg;
    assign cos_q31   = cos_reg;

endmodule

// ===== hdl/gcd_sqrt_cell.sv =====
// One step of the floor square root digit recurrence, registered.
module gcd_sqrt_cell
    import gcd_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  sq_t  in_v,
    input  sq_t  in_res,
    output logic out_valid,
    output sq_t  out_v,
    output sq_t  out_res
);

    localparam sq_t BIT = sq_t'(64'd1 << (62 - 2 * STEP));

    sq_t  trial;
    sq_t  v_next;
    sq_t  res_next;
    logic valid_reg;
    sq_t  v_reg;
    sq_t  res_reg;

    always_comb
    begin
        trial = in_res + BIT;
        if (in_v >= trial)
        begin
            v_next   = in_v - trial;
            res_next = (in_res >> 1) + BIT;
        end
        else
        begin
            v_next   = in_v;
            res_next = in_res >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign out_v     = v_reg;
    assign out_res   = res_reg;

endmodule

// ===== hdl/gcd_vec_cell.sv =====
// One vectoring-mode CORDIC iteration with its pipeline register.
module gcd_vec_cell
    import gcd_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  xy_t  in_x,
    input  xy_t  in_y,
    input  ang_t in_z,
    output logic out_valid,
    output xy_t  out_x,
    output xy_t  out_y,
    output ang_t out_z
);

    localparam ang_t ANGLE = ang_t'(atan_q48(STEP));

    xy_t  dx;
    xy_t  dy;
    xy_t  x_next;
    xy_t  y_next;
    ang_t z_next;
    logic valid_reg;
    xy_t  x_reg;
    xy_t  y_reg;
    ang_t z_reg;

    always_comb
    begin
        dx = in_y >>> STEP;
        dy = in_x >>> STEP;
        if (!in_y[XY_W-1])
        begin
            x_next = in_x + dx;
            y_next = in_y - dy;
            z_next = in_z + ANGLE;
        end
        else
        begin
            x_next = in_x - dx;
            y_next = in_y + dy;
            z_next = in_z - ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;

endmodule
